@@ rtl/c_esc_pkg.sv @@
// Shared types, codes and helpers for the C escape decoder.
package c_esc_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CAP_W       = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [CAP_W-1:0] CNT_MAX = CAP_W'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef logic [LENGTH_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_HEX2  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_summary;
        logic [15:0] length;
        t_status     status;
    } t_result;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic [15:0] len16(input t_count c);
        logic [CAP_W-1:0] w;
        w = CAP_W'(c);
        return w[15:0];
    endfunction

endpackage

@@ rtl/c_esc_decode.sv @@
// Input beat register, per-string state and escape decode logic.
module c_esc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_load,
    input  logic [7:0]          i_in_byte,
    input  logic                i_in_eot,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_emit,
    output c_esc_pkg::t_result  o_result
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eot;
    logic [15:0]          r_capacity;
    c_esc_pkg::t_mode     r_mode, n_mode;
    logic [3:0]           r_high, n_high;
    c_esc_pkg::t_count    r_count, n_count;
    c_esc_pkg::t_status   r_err, n_err;

    logic                 want;
    logic [7:0]           want_byte;
    logic [4:0]           hv;
    logic [c_esc_pkg::CAP_W-1:0] cap_ext, cap_eff;
    logic                 fire;
    c_esc_pkg::t_result   res;
    logic                 emit;

    assign hv      = c_esc_pkg::hex_value(r_in_byte);
    assign cap_ext = c_esc_pkg::CAP_W'(r_capacity);
    assign cap_eff = (cap_ext > c_esc_pkg::CNT_MAX) ? c_esc_pkg::CNT_MAX : cap_ext;

    always_comb begin
        n_mode    = r_mode;
        n_high    = r_high;
        n_count   = r_count;
        n_err     = r_err;
        want      = 1'b0;
        want_byte = r_in_byte;
        emit      = 1'b0;
        res       = '0;
        res.status = c_esc_pkg::ST_OK;
        if (r_in_eot) begin
            emit           = 1'b1;
            res.is_summary = 1'b1;
            res.length     = c_esc_pkg::len16(r_count);
            res.status     = (r_err == c_esc_pkg::ST_OK && r_mode != c_esc_pkg::MODE_PLAIN)
                             ? c_esc_pkg::ST_MALFORMED : r_err;
            n_mode  = c_esc_pkg::MODE_PLAIN;
            n_high  = '0;
            n_count = '0;
            n_err   = c_esc_pkg::ST_OK;
        end else if (r_err == c_esc_pkg::ST_OK) begin
            case (r_mode)
                c_esc_pkg::MODE_PLAIN: begin
                    if (r_in_byte == c_esc_pkg::CH_BSLASH) begin
                        n_mode = c_esc_pkg::MODE_ESC;
                    end else begin
                        want = 1'b1;
                    end
                end
                c_esc_pkg::MODE_ESC: begin
                    n_mode = c_esc_pkg::MODE_PLAIN;
                    case (r_in_byte)
                        c_esc_pkg::CH_BSLASH: begin
                            want = 1'b1;
                            want_byte = c_esc_pkg::CH_BSLASH;
                        end
                        c_esc_pkg::CH_N: begin
                            want = 1'b1;
                            want_byte = c_esc_pkg::CH_LF;
                        end
                        c_esc_pkg::CH_R: begin
                            want = 1'b1;
                            want_byte = c_esc_pkg::CH_CR;
                        end
                        c_esc_pkg::CH_T: begin
                            want = 1'b1;
                            want_byte = c_esc_pkg::CH_TAB;
                        end
                        c_esc_pkg::CH_X: begin
                            n_mode = c_esc_pkg::MODE_HEX1;
                        end
                        default: begin
                            n_err = c_esc_pkg::ST_MALFORMED;
                        end
                    endcase
                end
                c_esc_pkg::MODE_HEX1: begin
                    if (hv[4]) begin
                        n_mode = c_esc_pkg::MODE_PLAIN;
                        n_err  = c_esc_pkg::ST_MALFORMED;
                    end else begin
                        n_high = hv[3:0];
                        n_mode = c_esc_pkg::MODE_HEX2;
                    end
                end
                default: begin
                    n_mode = c_esc_pkg::MODE_PLAIN;
                    if (hv[4]) begin
                        n_err = c_esc_pkg::ST_MALFORMED;
                    end else begin
                        want = 1'b1;
                        want_byte = {r_high, hv[3:0]};
                    end
                end
            endcase
            if (want) begin
                if (c_esc_pkg::CAP_W'(r_count) >= cap_eff) begin
                    n_err = c_esc_pkg::ST_FULL;
                end else begin
                    emit         = 1'b1;
                    n_count      = r_count + 1'b1;
                    res.out_byte = want_byte;
                    res.length   = c_esc_pkg::len16(n_count);
                end
            end
        end
    end

    assign fire       = r_in_valid && (!emit || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign o_emit     = fire && emit;
    assign o_result   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_capacity <= 16'hFFFF;
            r_mode     <= c_esc_pkg::MODE_PLAIN;
            r_high     <= '0;
            r_count    <= '0;
            r_err      <= c_esc_pkg::ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_in_load) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode  <= n_mode;
                r_high  <= n_high;
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_load) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_in_eot;
        end
    end

endmodule

@@ rtl/c_esc_out.sv @@
// Result register on the master side.
module c_esc_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  c_esc_pkg::t_result  i_result,
    input  logic                i_m_tready,
    output logic                o_ready,
    output logic                o_m_tvalid,
    output logic [31:0]         o_m_tdata,
    output logic                o_m_tuser
);

    logic               r_valid;
    c_esc_pkg::t_result r_result;

    assign o_ready    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_result.status, r_result.length, r_result.out_byte};
    assign o_m_tuser  = r_result.is_summary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ rtl/c_escape_decoder_top.sv @@
// Top level of the C string escape decoder.
// Decodes backslash escapes in a byte stream, one source beat per clock cycle sustained
// while the master side accepts results. A beat is held in an input register, decoded
// against the per-string state and written to a result register, which a stall on the
// master side can delay; the state update loop sets the rate. tlast marks the end of a string
// (its tdata is ignored) and yields a summary beat, flagged by tuser, with the length and
// status. Capacity may only be written while the block is idle.
module c_escape_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // capacity
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,        // [7:0] text_byte
    input  logic        i_s_tlast,        // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,        // [7:0] out_byte, [23:8] length, [25:24] status
    output logic        o_m_tuser         // is_summary
);

    logic               in_load;
    logic               out_ready;
    logic               emit;
    c_esc_pkg::t_result result;

    assign in_load = i_s_tvalid && o_s_tready;

    c_esc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_load   (in_load),
        .i_in_byte   (i_s_tdata),
        .i_in_eot    (i_s_tlast),
        .i_out_ready (out_ready),
        .o_in_ready  (o_s_tready),
        .o_emit      (emit),
        .o_result    (result)
    );

    c_esc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit),
        .i_result   (result),
        .i_m_tready (i_m_tready),
        .o_ready    (out_ready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ tb/c_escape_decoder_top_tb.sv @@
// Self-checking testbench for the C string escape decoder top level.
`timescale 1ns / 1ps

module c_escape_decoder_top_tb;
    import c_esc_pkg::*;

    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RES} t_chk;
    typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_CAP} t_row;

    typedef struct {
        t_row        kind;
        logic [15:0] val;
        t_chk        ck;
        t_result     res;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    // per-beat override of the decoder prediction, travels with tdata
    t_chk    beat_chk;
    t_result beat_res;

    // decoder model state
    t_mode       dec_mode  = MODE_PLAIN;
    logic [3:0]  dec_hi    = '0;
    t_count      dec_count = '0;
    t_status     dec_err   = ST_OK;
    logic [15:0] dec_cap   = 16'hFFFF;

    t_result pending_results[$];
    t_dir_row dir_tab[$];
    int n_mismatch  = 0;
    int n_beats     = 0;
    int rx_hold_req = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;

    c_escape_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("c_escape_decoder_top_tb: FAIL");
        $finish;
    end

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void put_byte(input logic [7:0] b, output bit has, output t_result r);
        longint unsigned lim;
        lim = (64'd1 << LENGTH_BITS) - 64'd1;
        if (dec_cap < lim) lim = dec_cap;
        has = 1'b0;
        r = NO_RES;
        if (dec_count >= lim) begin
            dec_err = ST_FULL;
        end else begin
            dec_count = dec_count + 1'b1;
            has = 1'b1;
            r = '{b, 1'b0, 16'(dec_count), ST_OK};
        end
    endfunction

    function automatic void decode_beat(input logic [7:0] c, input logic eot,
                                        output bit has, output t_result r);
        int v;
        has = 1'b0;
        r = NO_RES;
        v = nibble_of(c);
        if (eot) begin
            if (dec_err == ST_OK && dec_mode != MODE_PLAIN) dec_err = ST_MALFORMED;
            has = 1'b1;
            r = '{8'h00, 1'b1, 16'(dec_count), dec_err};
            dec_mode = MODE_PLAIN;
            dec_hi = '0;
            dec_count = '0;
            dec_err = ST_OK;
        end else if (dec_err == ST_OK) begin
            case (dec_mode)
                MODE_PLAIN: begin
                    if (c == CH_BSLASH) dec_mode = MODE_ESC;
                    else put_byte(c, has, r);
                end
                MODE_ESC: begin
                    dec_mode = MODE_PLAIN;
                    case (c)
                        CH_BSLASH: put_byte(CH_BSLASH, has, r);
                        CH_N:      put_byte(CH_LF, has, r);
                        CH_R:      put_byte(CH_CR, has, r);
                        CH_T:      put_byte(CH_TAB, has, r);
                        CH_X:      dec_mode = MODE_HEX1;
                        default:   dec_err = ST_MALFORMED;
                    endcase
                end
                MODE_HEX1: begin
                    if (v < 0) begin
                        dec_mode = MODE_PLAIN;
                        dec_err = ST_MALFORMED;
                    end else begin
                        dec_hi = v[3:0];
                        dec_mode = MODE_HEX2;
                    end
                end
                default: begin
                    dec_mode = MODE_PLAIN;
                    if (v < 0) dec_err = ST_MALFORMED;
                    else put_byte({dec_hi, v[3:0]}, has, r);
                end
            endcase
        end
    endfunction

    function automatic void check_field(input string f, input logic [15:0] e,
                                        input logic [15:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, f, e, a);
            n_mismatch++;
        end
    endfunction

    // model runs on accepted beats, results checked in order
    always @(posedge i_clk) begin
        bit has;
        t_result exp_r;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_we) dec_cap = i_cfg_wdata;
            if (i_s_tvalid && o_s_tready) begin
                decode_beat(i_s_tdata, i_s_tlast, has, exp_r);
                if (beat_chk != CHK_PRED) begin
                    has = (beat_chk == CHK_RES);
                    exp_r = beat_res;
                end
                if (has) pending_results.push_back(exp_r);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata[7:0], o_m_tuser, o_m_tdata[23:8], t_status'(o_m_tdata[25:24])};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got byte %0h summary %0b len %0d st %0d",
                             $time, got.out_byte, got.is_summary, got.length, got.status);
                    n_mismatch++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("out_byte", exp_r.out_byte, got.out_byte);
                    check_field("is_summary", exp_r.is_summary, got.is_summary);
                    check_field("length", exp_r.length, got.length);
                    check_field("status", exp_r.status, got.status);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    initial begin
        int stall;
        stall = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                stall = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall == 0 && !rx_quiet) stall = pick_gap();
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last, input t_chk ck,
                             input t_result r);
        int g;
        g = tx_quiet ? 0 : pick_gap();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        beat_chk   <= ck;
        beat_res   <= r;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [15:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    task automatic send_string();
        logic [7:0] q[$];
        logic [7:0] b;
        int n;
        int k;
        int sel;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        sel = $urandom_range(0, 99);
        for (k = 0; k < n; k++) begin
            if (sel < 10) begin
                // noise from an escape-heavy alphabet
                case ($urandom_range(0, 5))
                    0:       b = CH_BSLASH;
                    1:       b = CH_X;
                    2:       b = 8'($urandom_range(8'h30, 8'h39));
                    3:       b = 8'($urandom_range(8'h61, 8'h67));
                    4:       b = 8'($urandom_range(8'h41, 8'h47));
                    default: b = CH_N;
                endcase
                q.push_back(b);
            end else begin
                case ($urandom_range(0, 9))
                    6: begin
                        q.push_back(CH_BSLASH);
                        q.push_back(CH_BSLASH);
                    end
                    7: begin
                        q.push_back(CH_BSLASH);
                        case ($urandom_range(0, 2))
                            0:       q.push_back(CH_N);
                            1:       q.push_back(CH_R);
                            default: q.push_back(CH_T);
                        endcase
                    end
                    8, 9: begin
                        q.push_back(CH_BSLASH);
                        q.push_back(CH_X);
                        q.push_back(hex_char($urandom_range(0, 15)));
                        q.push_back(hex_char($urandom_range(0, 15)));
                    end
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_BSLASH) b = 8'h5D;
                        q.push_back(b);
                    end
                endcase
            end
        end
        if (sel >= 10 && sel < 25) begin
            q.push_back(CH_BSLASH);
            case ($urandom_range(0, 3))
                0: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {CH_BSLASH, CH_N, CH_R, CH_T, CH_X});
                    q.push_back(b);
                end
                1: begin
                    q.push_back(CH_X);
                    do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
                    q.push_back(b);
                end
                2: begin
                    q.push_back(CH_X);
                    q.push_back(hex_char($urandom_range(0, 15)));
                    do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
                    q.push_back(b);
                end
                default: begin
                    // escape cut off by the end of the string
                    if ($urandom_range(0, 1)) begin
                        q.push_back(CH_X);
                        if ($urandom_range(0, 1)) q.push_back(hex_char($urandom_range(0, 15)));
                    end
                end
            endcase
            if (q[$] != CH_BSLASH && q[$] != CH_X && nibble_of(q[$]) < 0) begin
                n = $urandom_range(0, 3);
                for (k = 0; k < n; k++) q.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (q[i]) send_beat(q[i], 1'b0, CHK_PRED, NO_RES);
        send_beat(8'($urandom_range(0, 255)), 1'b1, CHK_PRED, NO_RES);
        n_beats += q.size() + 1;
    endtask

    initial begin
        logic [15:0] caps [7];
        int p;
        int start;
        bit paused;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        beat_chk    = CHK_PRED;
        beat_res    = NO_RES;
        paused      = 1'b0;

        dir_tab = '{
            '{ROW_BYTE, 16'h0001, CHK_RES,  '{8'h01, 1'b0, 16'd1, ST_OK}},
            '{ROW_BYTE, 16'h00FF, CHK_RES,  '{8'hFF, 1'b0, 16'd2, ST_OK}},
            '{ROW_BYTE, 16'h0000, CHK_RES,  '{8'h00, 1'b0, 16'd3, ST_OK}},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_N,      CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_R,      CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_T,      CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_X,      CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0046,  CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0061,  CHK_PRED, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd8, ST_OK}},
            // unknown escape, later bytes suppressed
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0071,  CHK_NONE, NO_RES},
            '{ROW_BYTE, 16'h005A,  CHK_NONE, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd0, ST_MALFORMED}},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_X,      CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0067,  CHK_NONE, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd0, ST_MALFORMED}},
            // end inside a hex escape
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_X,      CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0031,  CHK_PRED, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd0, ST_MALFORMED}},
            '{ROW_CAP,  16'h0000,  CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0041,  CHK_NONE, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd0, ST_FULL}},
            '{ROW_CAP,  16'h0002,  CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0041,  CHK_PRED, NO_RES},
            '{ROW_BYTE, 16'h0042,  CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_BSLASH, CHK_PRED, NO_RES},
            '{ROW_BYTE, CH_N,      CHK_NONE, NO_RES},
            '{ROW_END,  16'h00A5,  CHK_RES,  '{8'h00, 1'b1, 16'd2, ST_FULL}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CAP) write_cap(dir_tab[i].val);
            else send_beat(dir_tab[i].val[7:0], dir_tab[i].kind == ROW_END,
                           dir_tab[i].ck, dir_tab[i].res);
        end

        caps = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 12)),
                 16'($urandom_range(0, 65535)), 16'd7, 16'hFFFF};
        for (p = 0; p < 7; p++) begin
            write_cap(caps[p]);
            tx_quiet = (p == 2) || (p == 5);
            rx_quiet = (p == 2);
            // long receiver hold-off while the sender keeps pushing
            if (p == 5) rx_hold_req = 300;
            start = n_beats;
            while (n_beats - start < 75) begin
                send_string();
                if (p == 3 && !paused && n_beats - start >= 40) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("c_escape_decoder_top_tb: PASS");
        end else begin
            $display("c_escape_decoder_top_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/c_esc_pkg.sv
rtl/c_esc_decode.sv
rtl/c_esc_out.sv
rtl/c_escape_decoder_top.sv
tb/c_escape_decoder_top_tb.sv
